// ===== rtl/core/bfr_pkg.sv =====
// bitmap font text renderer: shared types and constants
// used by bfr_ctrl, bfr_dp and bitmap_font_text_renderer_core
package bfr_pkg;

	localparam int CELL_SIZE  = 8;
	localparam int ROW_W      = 3;
	localparam int CFG_DATA_W = 11;
	localparam int ADDR_W     = 20;
	localparam int PEN_X_W    = 16;
	localparam int PEN_Y_W    = 13;
	localparam logic [7:0] FIRST_CODE = 8'h20;
	localparam logic [PEN_X_W-1:0] PEN_X_MAX = 16'h7fff;

	typedef enum logic [2:0] {
		CFG_DEST_WIDTH     = 3'd0,
		CFG_DEST_HEIGHT    = 3'd1,
		CFG_FG_COLOUR      = 3'd2,
		CFG_BG_COLOUR      = 3'd3,
		CFG_BG_TRANSPARENT = 3'd4,
		CFG_PEN_ADVANCE    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FIRST,
		ST_DRAW
	} bfr_state_t;

	typedef struct packed {
		logic load;      // glyph row write transfer
		logic draw;      // draw item transfer
		logic mult;      // form the first row base address
		logic latch;     // take row 0 bits from the store
		logic prefetch;  // read the next row ahead
		logic emit;      // push one pixel into the output register
	} bfr_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic col_last;
		logic row_last;
	} bfr_sts_t;

endpackage

// ===== rtl/core/bfr_ctrl.sv =====
// bitmap font text renderer: controller state machine
// depends on bfr_pkg; drives bfr_dp through bfr_cmd_t
module bfr_ctrl
	import bfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     req_type,
	output logic     in_ready,
	input  bfr_sts_t sts,
	output bfr_cmd_t cmd
);

	bfr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type) begin
						cmd.draw = 1'b1;
						state_d  = ST_FETCH;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				cmd.mult = 1'b1;
				state_d  = ST_FIRST;
			end
			ST_FIRST: begin
				cmd.latch = 1'b1;
				state_d   = ST_DRAW;
			end
			ST_DRAW: begin
				cmd.prefetch = 1'b1;
				cmd.emit     = sts.slot_free;
				if (sts.slot_free && sts.col_last && sts.row_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_draw_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |=> state_q == ST_FETCH)
		else $error("draw transfer not followed by glyph fetch");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free)
		else $error("pixel pushed into a full output register");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.col_last && sts.row_last) |=> in_ready)
		else $error("not ready after the last pixel of a cell");

endmodule

// ===== rtl/core/bfr_dp.sv =====
// bitmap font text renderer: datapath with glyph store, pen, counters,
// configuration registers and output register; depends on bfr_pkg
module bfr_dp
	import bfr_pkg::*;
#(
	parameter int GLYPH_COUNT = 64,
	parameter int MAX_DIM     = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start_of_string,
	input  logic [12:0]           start_x,
	input  logic [12:0]           start_y,
	input  logic [7:0]            char_code,
	input  logic [5:0]            load_glyph,
	input  logic [2:0]            load_row,
	input  logic [7:0]            load_bits,
	input  bfr_cmd_t              cmd,
	output bfr_sts_t              sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  write_enable,
	output logic [ADDR_W-1:0]     pixel_address,
	output logic [7:0]            pixel_value,
	output logic                  last
);

	localparam int GW     = $clog2(GLYPH_COUNT);
	localparam int SA     = GW + ROW_W;
	localparam int DEPTH  = GLYPH_COUNT * CELL_SIZE;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
	localparam int PROD_W = PEN_Y_W + DIM_W + 1;
	localparam logic [DIM_W-1:0] RST_W = DIM_W'((MAX_DIM < 320) ? MAX_DIM : 320);
	localparam logic [DIM_W-1:0] RST_H = DIM_W'((MAX_DIM < 200) ? MAX_DIM : 200);

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic [7:0]       fg_q, bg_q;
	logic             transp_q;
	logic [3:0]       adv_q;
	logic [CMP_W-1:0] cfg_raw, cfg_dim;

	assign cfg_raw = CMP_W'(cfg_data);
	assign cfg_dim = (cfg_raw > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : cfg_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_W;
			height_q <= RST_H;
			fg_q     <= '0;
			bg_q     <= '0;
			transp_q <= 1'b0;
			adv_q    <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEST_WIDTH:     width_q  <= cfg_dim[DIM_W-1:0];
				CFG_DEST_HEIGHT:    height_q <= cfg_dim[DIM_W-1:0];
				CFG_FG_COLOUR:      fg_q     <= cfg_data[7:0];
				CFG_BG_COLOUR:      bg_q     <= cfg_data[7:0];
				CFG_BG_TRANSPARENT: transp_q <= cfg_data[0];
				CFG_PEN_ADVANCE:    adv_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// glyph store
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic          wr_ok;
	logic [SA-1:0] wr_addr, rd_addr;
	logic [GW-1:0] glyph_q, glyph_d;
	logic [7:0]    code_off;
	logic [ROW_W-1:0] row_q, col_q, rd_row;

	assign wr_ok   = {3'b000, load_glyph} < 9'(GLYPH_COUNT);
	assign wr_addr = {GW'(load_glyph), load_row};
	assign rd_row  = cmd.prefetch ? row_q + 1'b1 : row_q;
	assign rd_addr = {glyph_q, rd_row};

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			mem[wr_addr] <= load_bits;
		end
		rd_q <= mem[rd_addr];
	end

	// codes outside the font range fall back to glyph 0
	assign code_off = char_code - FIRST_CODE;
	always_comb begin
		glyph_d = '0;
		if (char_code >= FIRST_CODE && {1'b0, code_off} < 9'(GLYPH_COUNT)) begin
			glyph_d = GW'(code_off);
		end
	end

	// pen and cell walk
	logic [PEN_X_W-1:0] pen_x_q;
	logic [PEN_Y_W-1:0] pen_y_q;
	logic [PEN_X_W:0]   pen_nx;
	logic [ADDR_W-1:0]  base_q;
	logic [7:0]         bits_q;
	logic signed [PROD_W-1:0] prod;
	logic               last_pix;

	assign prod     = $signed(pen_y_q) * $signed({1'b0, width_q});
	assign pen_nx   = {pen_x_q[PEN_X_W-1], pen_x_q} + (PEN_X_W + 1)'(adv_q);
	assign last_pix = (col_q == 3'(CELL_SIZE - 1)) && (row_q == 3'(CELL_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (cmd.draw && start_of_string) begin
			pen_x_q <= {{(PEN_X_W - 13){start_x[12]}}, start_x};
			pen_y_q <= start_y;
		end else if (cmd.emit && last_pix) begin
			// only the upper bound can be crossed
			pen_x_q <= (!pen_nx[PEN_X_W] && pen_nx[PEN_X_W-1]) ? PEN_X_MAX
			                                                   : pen_nx[PEN_X_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			glyph_q <= glyph_d;
		end
		if (cmd.mult) begin
			base_q <= prod[ADDR_W-1:0];
		end else if (cmd.emit && col_q == 3'(CELL_SIZE - 1)) begin
			base_q <= base_q + ADDR_W'(width_q);
		end
		if (cmd.latch || (cmd.emit && col_q == 3'(CELL_SIZE - 1))) begin
			bits_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.draw) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.emit) begin
			col_q <= col_q + 1'b1;
			if (col_q == 3'(CELL_SIZE - 1)) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// pixel evaluation
	logic [PEN_X_W:0]   px;
	logic [PEN_Y_W:0]   py;
	logic               in_frame, lit, we;

	assign px       = {pen_x_q[PEN_X_W-1], pen_x_q} + (PEN_X_W + 1)'(col_q);
	assign py       = {pen_y_q[PEN_Y_W-1], pen_y_q} + (PEN_Y_W + 1)'(row_q);
	assign in_frame = !px[PEN_X_W] && (px[PEN_X_W-1:0] < PEN_X_W'(width_q))
	               && !py[PEN_Y_W] && (py[PEN_Y_W-1:0] < PEN_Y_W'(height_q));
	assign lit      = bits_q[col_q];
	assign we       = in_frame && (lit || !transp_q);

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			write_enable  <= we;
			pixel_address <= we ? base_q + ADDR_W'(px[PEN_X_W-1:0]) : '0;
			pixel_value   <= we ? (lit ? fg_q : bg_q) : '0;
			last          <= last_pix;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.col_last  = col_q == 3'(CELL_SIZE - 1);
	assign sts.row_last  = row_q == 3'(CELL_SIZE - 1);

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && last_pix) |=> (out_valid && last))
		else $error("final pixel of a cell not flagged last");

	a_pen_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!(pen_x_q[PEN_X_W-1] && pen_x_q[PEN_X_W-2:12] != '1))
		else $error("pen x below its lowest loadable value");

endmodule

// ===== rtl/core/bitmap_font_text_renderer_core.sv =====
// bitmap font text renderer top level: controller plus datapath
// depends on bfr_pkg, bfr_ctrl and bfr_dp
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    req_type .. load_bits
//   out       source     out_valid/out_ready  write_enable, pixel_address, pixel_value, last
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// a load item writes the glyph store as it is accepted; a draw item forms the row base
// address, latches row 0 from the glyph store, then emits one pixel a cycle while the
// output register is free, and it holds the last pixel while the next item is accepted
// a stalled out channel holds the walk; the pen moves after the 64th pixel
// reset clears control and pen and sets configuration to its defaults; the glyph store is not cleared
module bitmap_font_text_renderer_core
	import bfr_pkg::*;
#(
	parameter int GLYPH_COUNT = 64,
	parameter int MAX_DIM     = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic                  start_of_string,
	input  logic [12:0]           start_x,
	input  logic [12:0]           start_y,
	input  logic [7:0]            char_code,
	input  logic [5:0]            load_glyph,
	input  logic [2:0]            load_row,
	input  logic [7:0]            load_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_enable,
	output logic [ADDR_W-1:0]     pixel_address,
	output logic [7:0]            pixel_value,
	output logic                  last
);

	bfr_cmd_t cmd;
	bfr_sts_t sts;

	bfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfr_dp #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.MAX_DIM     (MAX_DIM)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start_of_string (start_of_string),
		.start_x         (start_x),
		.start_y         (start_y),
		.char_code       (char_code),
		.load_glyph      (load_glyph),
		.load_row        (load_row),
		.load_bits       (load_bits),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.write_enable    (write_enable),
		.pixel_address   (pixel_address),
		.pixel_value     (pixel_value),
		.last            (last)
	);

endmodule
